// ===== rtl/nfr_pkg.sv =====
// Package: word format, status codes and register indexes for the fifth-root unit.
`default_nettype none
package nfr_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int ITER_BITS = 6;
   localparam int ERR_BITS  = 31;
   localparam int STAT_BITS = 2;
   localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
   localparam int DCNT_BITS = $clog2(DIV_STEPS + 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        mag_type;

   localparam logic [STAT_BITS-1:0] STAT_CONVERGED = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_LIMIT     = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_ZERO_DER  = 2'd2;

   localparam logic [0:0] REG_ITER_LIMIT = 1'b0;
   localparam logic [0:0] REG_ERR_BOUND  = 1'b1;

   localparam logic [ITER_BITS-1:0] ITER_LIMIT_RESET = 6'd20;
   localparam logic [ERR_BITS-1:0]  ERR_BOUND_RESET  = 31'd655;

   localparam mag_type POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

   // saturate a sign and a wide magnitude to the word range
   function automatic word_type sat_word(input logic neg, input logic [2*WORD_BITS-1:0] mag);
      logic [2*WORD_BITS-1:0] lim;
      lim = {{WORD_BITS{1'b0}}, POS_MAX} + {{(2*WORD_BITS-1){1'b0}}, neg};
      if (mag > lim) mag = lim;
      sat_word = neg ? word_type'(-mag[WORD_BITS-1:0]) : word_type'(mag[WORD_BITS-1:0]);
   endfunction

   // saturating subtraction a - b
   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] d;
      d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (d[WORD_BITS] != d[WORD_BITS-1])
         sat_sub = d[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : word_type'(POS_MAX);
      else
         sat_sub = word_type'(d[WORD_BITS-1:0]);
   endfunction

   function automatic mag_type mag_of(input word_type v);
      mag_of = v[WORD_BITS-1] ? mag_type'(-v) : mag_type'(v);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/nfr_divider.sv =====
// Restoring divider: quotient floor(|n|*2^F/|d|), one bit a cycle, signed and saturated.
`default_nettype none
module nfr_divider (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire nfr_pkg::word_type num,
   input  wire nfr_pkg::word_type den,
   output logic                  done,
   output nfr_pkg::word_type     quot
);
   import nfr_pkg::*;

   logic [WORD_BITS:0]     rem_ff, rem_in;
   logic [QUOT_BITS-1:0]   q_ff, q_in;
   logic [QUOT_BITS-1:0]   sh_ff, sh_in;
   mag_type                md_ff, md_in;
   logic                   neg_ff, neg_in;
   logic [DCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [WORD_BITS:0]     trial;

   assign trial = {rem_ff[WORD_BITS-1:0], sh_ff[QUOT_BITS-1]};

   // one quotient bit a cycle
   always_comb begin
      rem_in = rem_ff; q_in = q_ff; sh_in = sh_ff; md_in = md_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = '0;
         sh_in   = {mag_of(num), {FRAC_BITS{1'b0}}};
         md_in   = mag_of(den);
         neg_in  = num[WORD_BITS-1] ^ den[WORD_BITS-1];
         cnt_in  = DCNT_BITS'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = sh_ff << 1;
         if (trial >= {1'b0, md_ff}) begin
            rem_in = trial - {1'b0, md_ff};
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; q_ff <= q_in; sh_ff <= sh_in; md_ff <= md_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = sat_word(neg_ff, {{(2*WORD_BITS-QUOT_BITS){1'b0}}, q_ff});
endmodule
`default_nettype wire

// ===== rtl/newton_fifth_root_unit.sv =====
// Top level: Newton-Raphson fifth root with a shared multiplier and divider.
// Per iteration: x^2, x^4 and x^5 - target with the multiplier, the error over 100, a check,
// then the divide by 5*x^4 and the root update; up to limit+1 iterations an item.
// Throughput: one item at a time; req_tready is low from acceptance until
// the result transfer. Set by the serial divider (48 steps) and iteration count.
// Reset: synchronous; registers return to limit 20 and bound 655, sequencer idle.
`default_nettype none
module newton_fifth_root_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // target_value[31:0], initial_guess[63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // root_estimate[31:0], iterations_used[37:32],
                                         // final_error[68:38], status[70:69], zero pad
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import nfr_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_X2 = 4'd1, ST_X4 = 4'd2, ST_X5 = 4'd3,
                          ST_ERR = 4'd4, ST_CHK = 4'd5, ST_DIV = 4'd6, ST_WAIT = 4'd7,
                          ST_OUT = 4'd8;

   // divide by 100 as multiply by ceil(2^37/100) and shift right by 37
   localparam logic [WORD_BITS-1:0] RECIP_100   = 32'h51EB_851F;
   localparam int                   RECIP_SHIFT = 37;

   logic [3:0]           st_ff, st_in;
   logic [ITER_BITS-1:0] lim_ff;
   logic [ERR_BITS-1:0]  bnd_ff;
   word_type             c_ff, x_ff, x2_ff, x4_ff, f_ff, x_in, x2_in, x4_in, f_in;
   logic [ITER_BITS-1:0] it_ff, it_in;
   logic [WORD_BITS-1:0] err_ff, err_in;
   logic [STAT_BITS-1:0] stat_ff, stat_in;
   logic                 ovalid_ff, ovalid_in;
   word_type             ma, mb, mres, quot, dval;
   logic [2*WORD_BITS-1:0] prod;
   logic [2*WORD_BITS-1:0] eprod;
   logic                 div_start, div_done, wr;
   logic [WORD_BITS+2:0] d5;

   // shared multiplier, product truncated toward zero then saturated
   assign prod = 64'(mag_of(ma)) * 64'(mag_of(mb));
   assign mres = sat_word(ma[WORD_BITS-1] ^ mb[WORD_BITS-1], prod >> FRAC_BITS);
   assign d5   = {3'b0, mag_of(x4_ff)} * 35'd5;
   assign dval = sat_word(x4_ff[WORD_BITS-1], {{(WORD_BITS-3){1'b0}}, d5});

   // error magnitude over 100 by reciprocal multiplication
   assign eprod = 64'(mag_of(f_ff)) * 64'(RECIP_100);

   nfr_divider u_div (.clock(clock), .reset(reset), .start(div_start), .num(f_ff),
                      .den(dval), .done(div_done), .quot(quot));

   always_comb begin
      st_in = st_ff; x_in = x_ff; x2_in = x2_ff; x4_in = x4_ff; f_in = f_ff;
      it_in = it_ff; err_in = err_ff; stat_in = stat_ff; ovalid_in = ovalid_ff;
      div_start = 1'b0;
      ma = x_ff; mb = x_ff;
      unique case (st_ff)
         ST_IDLE: if (req_tvalid) begin
            x_in = req_tdata[63:32]; it_in = '0; st_in = ST_X2;
         end
         ST_X2: begin x2_in = mres; st_in = ST_X4; end
         ST_X4: begin ma = x2_ff; mb = x2_ff; x4_in = mres; st_in = ST_X5; end
         ST_X5: begin ma = x4_ff; f_in = sat_sub(mres, c_ff); st_in = ST_ERR; end
         ST_ERR: begin err_in = WORD_BITS'(eprod >> RECIP_SHIFT); st_in = ST_CHK; end
         ST_CHK: begin
            if (err_ff <= {1'b0, bnd_ff}) begin
               stat_in = STAT_CONVERGED; st_in = ST_OUT;
            end else if (dval == '0) begin
               stat_in = STAT_ZERO_DER; st_in = ST_OUT;
            end else begin
               div_start = 1'b1; st_in = ST_DIV;
            end
         end
         ST_DIV: if (div_done) begin
            x_in = sat_sub(x_ff, quot);
            if (it_ff == lim_ff) begin
               stat_in = STAT_LIMIT; st_in = ST_OUT;
            end else begin
               it_in = it_ff + 1'b1; st_in = ST_X2;
            end
         end
         ST_OUT: begin ovalid_in = 1'b1; st_in = ST_WAIT; end
         ST_WAIT: if (rsp_tready) begin ovalid_in = 1'b0; st_in = ST_IDLE; end
         default: st_in = ST_IDLE;
      endcase
   end

   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      x_ff <= x_in; x2_ff <= x2_in; x4_ff <= x4_in; f_ff <= f_in;
      it_ff <= it_in; err_ff <= err_in; stat_ff <= stat_in;
      if (st_ff == ST_IDLE && req_tvalid) c_ff <= req_tdata[31:0];
      if (reset) begin
         st_ff <= ST_IDLE; ovalid_ff <= 1'b0;
         lim_ff <= ITER_LIMIT_RESET; bnd_ff <= ERR_BOUND_RESET;
      end else begin
         st_ff <= st_in; ovalid_ff <= ovalid_in;
         if (wr && csr_paddr[2] == REG_ITER_LIMIT && csr_paddr[1:0] == 2'b00)
            lim_ff <= csr_pwdata[ITER_BITS-1:0];
         if (wr && csr_paddr[2] == REG_ERR_BOUND && csr_paddr[1:0] == 2'b00)
            bnd_ff <= csr_pwdata[ERR_BITS-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ITER_LIMIT: csr_prdata = {26'b0, lim_ff};
         default:        csr_prdata = {1'b0, bnd_ff};
      endcase
   end
   assign csr_pready = 1'b1;

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {1'b0, stat_ff, err_ff[ERR_BITS-1:0], it_ff, x_ff};

   // a result is only offered while the sequencer waits for its transfer
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> st_ff == ST_WAIT) else $error("result shown outside wait");
   // no input is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input ready with result pending");
   // checks that the iteration index at the check state has not passed the limit
   a_iter: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHK) |-> it_ff <= lim_ff) else $error("iteration past limit");
endmodule
`default_nettype wire
